[hdl/online_ball_threshold_learner_assert.svh]
// assertion macros for the learner rtl
`ifndef ONLINE_BALL_THRESHOLD_LEARNER_ASSERT_SVH
`define ONLINE_BALL_THRESHOLD_LEARNER_ASSERT_SVH

// condition must hold on every clock out of reset
`define OBTL_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("obtl invariant violated");

// consequence must hold in the cycle after the trigger
`define OBTL_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("obtl sequence violated");

`endif

[hdl/obtl_pkg.sv]
`timescale 1ns / 1ps

package obtl_pkg;

    localparam int DEF_CACHE_DEPTH  = 64;
    localparam int DEF_MAX_FEATURES = 16;

    localparam int ELEM_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int DIST_W    = 38;
    localparam int SQ_W      = 34;
    localparam int OUT_SUM_W = 22;
    localparam int LIMIT_W   = 7;
    localparam int FCOUNT_W  = 5;

    localparam logic [LIMIT_W-1:0]  RESET_CACHE_LIMIT   = 7'd50;
    localparam logic [FCOUNT_W-1:0] RESET_FEATURE_COUNT = 5'd16;

    // configuration register indexes
    localparam logic REG_CACHE_LIMIT   = 1'b0;
    localparam logic REG_FEATURE_COUNT = 1'b1;

    // input kinds
    localparam logic OP_CENTER  = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0]   sq_dist;
        logic [WEIGHT_W-1:0] weight;
        logic                positive;
    } entry_t;

endpackage

[hdl/online_ball_threshold_learner.sv]
`timescale 1ns / 1ps

// ball threshold learner: centre beats (tuser 0) load the centre and clear the
// cache; feature beats (tuser 1) accumulate the squared distance of the current
// instance, and the beat with tlast closes the bag and yields one result beat.
// a centre beat is taken in idle, a feature beat passes through the multiply and
// accumulate states. a bag end walks the cache memory (one write port, one read
// port), reading each entry visited and then using it: one pass to find the
// insert slot and the lightest entry, an eviction shift and an insertion shift
// that together can move close to two passes of entries, and one scan pass for
// the best radius, then any wait on m_tready. s_tready is low while a beat is
// being worked on.
module online_ball_threshold_learner
    import obtl_pkg::*;
#(
    parameter int CACHE_DEPTH  = DEF_CACHE_DEPTH,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // element_value[15:0], instance_end[16], bag_positive[17], bag_weight[33:18]
    input  logic [39:0]         s_tdata,
    // opcode
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // radius_squared[37:0], accept_all[38], error_weight[60:39],
    // total_weight[82:61], bag_distance[120:83], bag_dropped[121], fault[122]
    output logic [127:0]        m_tdata,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [LIMIT_W-1:0]  cfg_data
);

    `include "online_ball_threshold_learner_assert.svh"

    localparam int AW = $clog2(CACHE_DEPTH);
    localparam int CW = $clog2(CACHE_DEPTH + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int IW = $clog2(MAX_FEATURES + 1);
    localparam int NW = (IW > FCOUNT_W) ? IW : FCOUNT_W;
    localparam int SW = (WEIGHT_W + CW > OUT_SUM_W + 1) ? WEIGHT_W + CW : OUT_SUM_W + 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ACC   = 4'd2;
    localparam logic [3:0] ST_F_RD  = 4'd3;
    localparam logic [3:0] ST_F_USE = 4'd4;
    localparam logic [3:0] ST_EVAL  = 4'd5;
    localparam logic [3:0] ST_E_RD  = 4'd6;
    localparam logic [3:0] ST_E_USE = 4'd7;
    localparam logic [3:0] ST_I_RD  = 4'd8;
    localparam logic [3:0] ST_I_USE = 4'd9;
    localparam logic [3:0] ST_SINIT = 4'd10;
    localparam logic [3:0] ST_S_RD  = 4'd11;
    localparam logic [3:0] ST_S_USE = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;

    localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1};

    logic [3:0]            state_reg, state_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [FCOUNT_W-1:0]   fcount_reg, fcount_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         light_reg, light_next;
    logic [WEIGHT_W-1:0]   lw_reg, lw_next;
    logic                  lpos_reg, lpos_next;
    logic [SW-1:0]         psum_reg, psum_next;
    logic [SW-1:0]         nsum_reg, nsum_next;
    logic [SW-1:0]         fr_reg, fr_next;
    logic [SW-1:0]         fa_reg, fa_next;
    logic [SW-1:0]         minerr_reg, minerr_next;
    logic [DIST_W-1:0]     best_reg, best_next;
    logic [DIST_W-1:0]     prev_reg, prev_next;
    logic [DIST_W-1:0]     partial_reg, partial_next;
    logic [DIST_W-1:0]     near_reg, near_next;
    logic                  nv_reg, nv_next;
    logic [DIST_W-1:0]     bagd_reg, bagd_next;
    logic                  dropped_reg, dropped_next;
    logic [ELEM_W-1:0]     val_reg, val_next;
    logic                  iend_reg, iend_next;
    logic                  bend_reg, bend_next;
    logic                  bpos_reg, bpos_next;
    logic [WEIGHT_W-1:0]   bw_reg, bw_next;
    logic                  ovalid_reg, ovalid_next;
    logic [127:0]          odata_reg, odata_next;

    logic                  accept_in;
    logic [NW-1:0]         n_eff;
    logic [LW-1:0]         lim_eff;
    logic                  use_elem;
    logic [SQ_W-1:0]       sq;
    logic [DIST_W:0]       psum_wide;
    logic [DIST_W-1:0]     partial_new;
    logic                  center_we;
    logic [CW-1:0]         i_m1;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    entry_t                mem_wdata;
    entry_t                rd;
    logic [SW-1:0]         total;
    logic [SW-1:0]         frfa;
    logic [SW+3:0]         fr_x10;
    logic                  fin_accept;
    logic [SW-1:0]         fin_err;
    logic [OUT_SUM_W-1:0]  err_sat;
    logic [OUT_SUM_W-1:0]  total_sat;
    logic                  fin_fault;

    assign accept_in = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;

    always_comb
    begin
        if (fcount_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(fcount_reg) > NW'(MAX_FEATURES))
        begin
            n_eff = NW'(MAX_FEATURES);
        end
        else
        begin
            n_eff = NW'(fcount_reg);
        end
        if (limit_reg == '0)
        begin
            lim_eff = LW'(1);
        end
        else if (LW'(limit_reg) > LW'(CACHE_DEPTH))
        begin
            lim_eff = LW'(CACHE_DEPTH);
        end
        else
        begin
            lim_eff = LW'(limit_reg);
        end
    end

    assign use_elem  = NW'(idx_reg) < n_eff;
    assign center_we = accept_in && (s_tuser == OP_CENTER) && use_elem;

    obtl_dist #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .center_we   (center_we),
        .idx         (idx_reg[FW-1:0]),
        .center_data (s_tdata[ELEM_W-1:0]),
        .feat_val    (val_reg),
        .sq          (sq)
    );

    // saturating distance accumulate
    assign psum_wide   = {1'b0, partial_reg} + (DIST_W+1)'(use_elem ? sq : '0);
    assign partial_new = psum_wide[DIST_W] ? '1 : psum_wide[DIST_W-1:0];

    assign i_m1 = i_reg - ONE_C;

    always_comb
    begin
        mem_raddr = i_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = i_reg[AW-1:0];
        mem_wdata = rd;
        unique case (state_reg)
            ST_E_USE:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_m1[AW-1:0];
            end
            ST_I_RD:
            begin
                mem_raddr = i_m1[AW-1:0];
                if (i_reg == pos_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg[AW-1:0];
                    mem_wdata = '{sq_dist: bagd_reg, weight: bw_reg, positive: bpos_reg};
                end
            end
            ST_I_USE:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    obtl_cache #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_cache (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd)
    );

    assign total      = psum_reg + nsum_reg;
    assign frfa       = fr_reg + fa_reg;
    assign fr_x10     = {fr_reg, 3'b000} + {2'b00, fr_reg, 1'b0};
    assign fin_accept = fa_reg < minerr_reg;
    assign fin_err    = fin_accept ? fa_reg : minerr_reg;
    assign err_sat    = (|fin_err[SW-1:OUT_SUM_W]) ? '1 : fin_err[OUT_SUM_W-1:0];
    assign total_sat  = (|total[SW-1:OUT_SUM_W]) ? '1 : total[OUT_SUM_W-1:0];
    assign fin_fault  = (total != '0) && (fr_x10 > (SW+4)'(total));

    always_comb
    begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        fcount_next  = fcount_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        pos_next     = pos_reg;
        light_next   = light_reg;
        lw_next      = lw_reg;
        lpos_next    = lpos_reg;
        psum_next    = psum_reg;
        nsum_next    = nsum_reg;
        fr_next      = fr_reg;
        fa_next      = fa_reg;
        minerr_next  = minerr_reg;
        best_next    = best_reg;
        prev_next    = prev_reg;
        partial_next = partial_reg;
        near_next    = near_reg;
        nv_next      = nv_reg;
        bagd_next    = bagd_reg;
        dropped_next = dropped_reg;
        val_next     = val_reg;
        iend_next    = iend_reg;
        bend_next    = bend_reg;
        bpos_next    = bpos_reg;
        bw_next      = bw_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            if (cfg_index == REG_CACHE_LIMIT)
            begin
                limit_next = cfg_data;
            end
            else
            begin
                fcount_next = cfg_data[FCOUNT_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (s_tuser == OP_CENTER)
                    begin
                        count_next   = '0;
                        psum_next    = '0;
                        nsum_next    = '0;
                        partial_next = '0;
                        near_next    = '0;
                        nv_next      = 1'b0;
                        if (s_tdata[16])
                        begin
                            idx_next = '0;
                        end
                        else if (idx_reg < IW'(MAX_FEATURES))
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        val_next   = s_tdata[ELEM_W-1:0];
                        iend_next  = s_tdata[16];
                        bpos_next  = s_tdata[17];
                        bw_next    = s_tdata[33:18];
                        bend_next  = s_tlast;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                partial_next = partial_new;
                if (idx_reg < IW'(MAX_FEATURES))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                state_next = ST_IDLE;
                if (iend_reg || bend_reg)
                begin
                    if (!nv_reg || partial_new < near_reg)
                    begin
                        near_next = partial_new;
                        bagd_next = partial_new;
                    end
                    else
                    begin
                        bagd_next = near_reg;
                    end
                    nv_next      = 1'b1;
                    partial_next = '0;
                    idx_next     = '0;
                end
                if (bend_reg)
                begin
                    i_next       = '0;
                    pos_next     = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_F_RD;
                end
            end
            ST_F_RD:
            begin
                state_next = (i_reg == count_reg) ? ST_EVAL : ST_F_USE;
            end
            ST_F_USE:
            begin
                // first lightest entry wins ties
                if (i_reg == '0 || rd.weight < lw_reg)
                begin
                    lw_next    = rd.weight;
                    light_next = i_reg;
                    lpos_next  = rd.positive;
                end
                if (bagd_reg > rd.sq_dist)
                begin
                    pos_next = i_reg + ONE_C;
                end
                i_next     = i_reg + ONE_C;
                state_next = ST_F_RD;
            end
            ST_EVAL:
            begin
                if (LW'(count_reg) >= lim_eff)
                begin
                    if (bw_reg <= lw_reg)
                    begin
                        dropped_next = 1'b1;
                        state_next   = ST_SINIT;
                    end
                    else
                    begin
                        if (light_reg < pos_reg)
                        begin
                            pos_next = pos_reg - ONE_C;
                        end
                        if (lpos_reg)
                        begin
                            psum_next = psum_reg - SW'(lw_reg);
                        end
                        else
                        begin
                            nsum_next = nsum_reg - SW'(lw_reg);
                        end
                        i_next     = light_reg + ONE_C;
                        state_next = ST_E_RD;
                    end
                end
                else
                begin
                    i_next     = count_reg;
                    state_next = ST_I_RD;
                end
            end
            ST_E_RD:
            begin
                if (i_reg == count_reg)
                begin
                    count_next = count_reg - ONE_C;
                    i_next     = count_reg - ONE_C;
                    state_next = ST_I_RD;
                end
                else
                begin
                    state_next = ST_E_USE;
                end
            end
            ST_E_USE:
            begin
                i_next     = i_reg + ONE_C;
                state_next = ST_E_RD;
            end
            ST_I_RD:
            begin
                if (i_reg == pos_reg)
                begin
                    count_next = count_reg + ONE_C;
                    if (bpos_reg)
                    begin
                        psum_next = psum_reg + SW'(bw_reg);
                    end
                    else
                    begin
                        nsum_next = nsum_reg + SW'(bw_reg);
                    end
                    state_next = ST_SINIT;
                end
                else
                begin
                    state_next = ST_I_USE;
                end
            end
            ST_I_USE:
            begin
                i_next     = i_m1;
                state_next = ST_I_RD;
            end
            ST_SINIT:
            begin
                fr_next     = psum_reg;
                fa_next     = '0;
                minerr_next = psum_reg;
                best_next   = '0;
                i_next      = '0;
                state_next  = ST_S_RD;
            end
            ST_S_RD:
            begin
                state_next = (i_reg == count_reg) ? ST_FIN : ST_S_USE;
            end
            ST_S_USE:
            begin
                // a threshold is tried only at the first entry of each distance
                if ((i_reg == '0 || rd.sq_dist != prev_reg) && frfa < minerr_reg)
                begin
                    best_next   = rd.sq_dist;
                    minerr_next = frfa;
                end
                if (rd.positive)
                begin
                    fr_next = fr_reg - SW'(rd.weight);
                end
                else
                begin
                    fa_next = fa_reg + SW'(rd.weight);
                end
                prev_next  = rd.sq_dist;
                i_next     = i_reg + ONE_C;
                state_next = ST_S_RD;
            end
            ST_FIN:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {5'b00000, fin_fault, dropped_reg, bagd_reg,
                                   total_sat, err_sat, fin_accept,
                                   fin_accept ? {DIST_W{1'b0}} : best_reg};
                    nv_next     = 1'b0;
                    near_next   = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            limit_reg   <= RESET_CACHE_LIMIT;
            fcount_reg  <= RESET_FEATURE_COUNT;
            idx_reg     <= '0;
            count_reg   <= '0;
            psum_reg    <= '0;
            nsum_reg    <= '0;
            partial_reg <= '0;
            near_reg    <= '0;
            nv_reg      <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            fcount_reg  <= fcount_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            psum_reg    <= psum_next;
            nsum_reg    <= nsum_next;
            partial_reg <= partial_next;
            near_reg    <= near_next;
            nv_reg      <= nv_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        pos_reg     <= pos_next;
        light_reg   <= light_next;
        lw_reg      <= lw_next;
        lpos_reg    <= lpos_next;
        fr_reg      <= fr_next;
        fa_reg      <= fa_next;
        minerr_reg  <= minerr_next;
        best_reg    <= best_next;
        prev_reg    <= prev_next;
        bagd_reg    <= bagd_next;
        dropped_reg <= dropped_next;
        val_reg     <= val_next;
        iend_reg    <= iend_next;
        bend_reg    <= bend_next;
        bpos_reg    <= bpos_next;
        bw_reg      <= bw_next;
        odata_reg   <= odata_next;
    end

    `OBTL_ASSERT_ALWAYS(a_count_in_range, count_reg <= CW'(CACHE_DEPTH))
    `OBTL_ASSERT_NEXT(a_bag_end_busy,
        s_tvalid && s_tready && (s_tuser == OP_FEATURE) && s_tlast, !s_tready)
    `OBTL_ASSERT_ALWAYS(a_accept_zero_radius,
        !(m_tvalid && m_tdata[38]) || (m_tdata[37:0] == '0))

endmodule

[hdl/obtl_dist.sv]
`timescale 1ns / 1ps

module obtl_dist
    import obtl_pkg::*;
#(
    parameter int MAX_FEATURES = DEF_MAX_FEATURES
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         center_we,
    input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] idx,
    input  logic [ELEM_W-1:0]            center_data,
    input  logic [ELEM_W-1:0]            feat_val,
    output logic [SQ_W-1:0]              sq
);

    logic [ELEM_W-1:0]       center_mem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0] valid_reg;
    logic [ELEM_W-1:0]       rd_reg;
    logic                    rd_valid_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic signed [ELEM_W:0]  diff;
    logic signed [2*ELEM_W+1:0] prod;

    always_ff @(posedge clk)
    begin
        if (center_we)
        begin
            center_mem[idx] <= center_data;
        end
        rd_reg <= center_mem[idx];
    end

    // never-written centre entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (center_we)
            begin
                valid_reg[idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[idx];
        end
    end

    always_comb
    begin
        diff = $signed({rd_valid_reg & rd_reg[ELEM_W-1], rd_valid_reg ? rd_reg : '0})
             - $signed({feat_val[ELEM_W-1], feat_val});
        prod = diff * diff;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= prod[SQ_W-1:0];
    end

    assign sq = sq_reg;

endmodule

[hdl/obtl_cache.sv]
`timescale 1ns / 1ps

module obtl_cache
    import obtl_pkg::*;
#(
    parameter int CACHE_DEPTH = DEF_CACHE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(CACHE_DEPTH)-1:0] waddr,
    input  entry_t                         wdata,
    input  logic [$clog2(CACHE_DEPTH)-1:0] raddr,
    output entry_t                         rdata
);

    entry_t mem [CACHE_DEPTH];
    entry_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;

endmodule

[verif/tb_online_ball_threshold_learner.sv]
`timescale 1ns / 1ps

module tb_online_ball_threshold_learner;
    import obtl_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 600;
    localparam int DEPTH       = DEF_CACHE_DEPTH;
    localparam int NFEAT       = DEF_MAX_FEATURES;
    localparam longint unsigned DMAX = (64'd1 << DIST_W) - 1;
    localparam longint unsigned WMAX = (64'd1 << OUT_SUM_W) - 1;

    typedef struct {
        logic [DIST_W-1:0]    radius;
        logic                 accept;
        logic [OUT_SUM_W-1:0] err;
        logic [OUT_SUM_W-1:0] tot;
        logic [DIST_W-1:0]    bdist;
        logic                 dropped;
        logic                 fault;
    } ball_result_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;
    logic               s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [127:0]       m_tdata;
    logic               cfg_we;
    logic               cfg_index;
    logic [LIMIT_W-1:0] cfg_data;

    online_ball_threshold_learner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // learner mirror
    int                center_val [NFEAT];
    longint unsigned   cache_dist [DEPTH];
    int unsigned       cache_wt   [DEPTH];
    bit                cache_pos  [DEPTH];
    int                cached;
    longint unsigned   pos_weight;
    longint unsigned   neg_weight;
    longint unsigned   running_dist;
    longint unsigned   closest_dist;
    bit                closest_seen;
    int                elem_idx;
    int                limit_reg;
    int                fcount_reg;

    ball_result_t      pending_results [$];
    int                cycles;
    int                errors;
    int                beats_sent;
    int                results_seen;
    int                drops_seen;
    int                accepts_seen;
    bit                idle_on;
    int                stall_left;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_limit();
        return (limit_reg == 0) ? 1 : (limit_reg > DEPTH ? DEPTH : limit_reg);
    endfunction

    function automatic int eff_features();
        return (fcount_reg == 0) ? 1 : (fcount_reg > NFEAT ? NFEAT : fcount_reg);
    endfunction

    function automatic void clear_learner();
        cached       = 0;
        pos_weight   = 0;
        neg_weight   = 0;
        running_dist = 0;
        closest_dist = 0;
        closest_seen = 0;
    endfunction

    function automatic bit cache_insert(longint unsigned d, bit p, int unsigned w);
        int slot;
        int light;
        slot  = 0;
        light = 0;
        for (int i = 0; i < cached; i++)
        begin
            if (cache_wt[i] < cache_wt[light]) light = i;
            if (d > cache_dist[i]) slot = i + 1;
        end
        if (cached >= eff_limit())
        begin
            if (w <= cache_wt[light]) return 1'b1;
            if (light < slot) slot--;
            if (cache_pos[light]) pos_weight -= cache_wt[light];
            else neg_weight -= cache_wt[light];
            for (int j = light; j < cached - 1; j++)
            begin
                cache_dist[j] = cache_dist[j+1];
                cache_wt[j]   = cache_wt[j+1];
                cache_pos[j]  = cache_pos[j+1];
            end
            cached--;
        end
        for (int j = cached; j > slot; j--)
        begin
            cache_dist[j] = cache_dist[j-1];
            cache_wt[j]   = cache_wt[j-1];
            cache_pos[j]  = cache_pos[j-1];
        end
        cache_dist[slot] = d;
        cache_wt[slot]   = w;
        cache_pos[slot]  = p;
        cached++;
        if (p) pos_weight += w;
        else neg_weight += w;
        return 1'b0;
    endfunction

    // one accepted beat through the mirror; queues a result at bag end
    function automatic void learner_step(logic op, logic signed [ELEM_W-1:0] v, logic ie,
                                         logic be, logic p, logic [WEIGHT_W-1:0] w);
        longint          diff;
        longint unsigned bag_d;
        longint unsigned fr;
        longint unsigned fa;
        longint unsigned minerr;
        longint unsigned best;
        longint unsigned total;
        longint unsigned thr;
        bit              dropped;
        bit              acc;
        int              i;
        ball_result_t    r;
        if (op == OP_CENTER)
        begin
            clear_learner();
            if (elem_idx < eff_features()) center_val[elem_idx] = int'(v);
            if (elem_idx < NFEAT) elem_idx++;
            if (ie) elem_idx = 0;
            return;
        end
        if (elem_idx < eff_features())
        begin
            diff = longint'(center_val[elem_idx]) - longint'(int'(v));
            running_dist += longint'(diff * diff);
            if (running_dist > DMAX) running_dist = DMAX;
        end
        if (elem_idx < NFEAT) elem_idx++;
        if (ie || be)
        begin
            if (!closest_seen || running_dist < closest_dist) closest_dist = running_dist;
            closest_seen = 1;
            running_dist = 0;
            elem_idx     = 0;
        end
        if (!be) return;
        bag_d        = closest_dist;
        dropped      = cache_insert(bag_d, p, w);
        closest_seen = 0;
        closest_dist = 0;
        fr     = pos_weight;
        fa     = 0;
        minerr = pos_weight;
        best   = 0;
        total  = pos_weight + neg_weight;
        acc    = 0;
        i      = 0;
        while (i < cached)
        begin
            thr = cache_dist[i];
            if (fr + fa < minerr)
            begin
                best   = thr;
                minerr = fr + fa;
            end
            do
            begin
                if (cache_pos[i]) fr -= cache_wt[i];
                else fa += cache_wt[i];
                i++;
            end
            while (i < cached && cache_dist[i] == thr);
        end
        if (fa < minerr)
        begin
            acc    = 1;
            best   = 0;
            minerr = fa;
        end
        r.radius  = best[DIST_W-1:0];
        r.accept  = acc;
        r.err     = (minerr > WMAX) ? WMAX[OUT_SUM_W-1:0] : minerr[OUT_SUM_W-1:0];
        r.tot     = (total > WMAX) ? WMAX[OUT_SUM_W-1:0] : total[OUT_SUM_W-1:0];
        r.bdist   = bag_d[DIST_W-1:0];
        r.dropped = dropped;
        r.fault   = (total != 0) && (fr * 10 > total);
        pending_results = {pending_results, r};
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    endtask

    // result side: sample at the rising edge, draw a stall per beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            stall_left <= idle_on ? $urandom_range(0, 10) : 0;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result beat", 0, 0);
            else
            begin
                ball_result_t e;
                e = pending_results.pop_front();
                if (m_tdata[121]) drops_seen++;
                if (m_tdata[38]) accepts_seen++;
                if (m_tdata[37:0] !== e.radius)
                    report_mismatch("radius_squared", m_tdata[37:0], e.radius);
                if (m_tdata[38] !== e.accept)
                    report_mismatch("accept_all", m_tdata[38], e.accept);
                if (m_tdata[60:39] !== e.err)
                    report_mismatch("error_weight", m_tdata[60:39], e.err);
                if (m_tdata[82:61] !== e.tot)
                    report_mismatch("total_weight", m_tdata[82:61], e.tot);
                if (m_tdata[120:83] !== e.bdist)
                    report_mismatch("bag_distance", m_tdata[120:83], e.bdist);
                if (m_tdata[121] !== e.dropped)
                    report_mismatch("bag_dropped", m_tdata[121], e.dropped);
                if (m_tdata[122] !== e.fault)
                    report_mismatch("fault", m_tdata[122], e.fault);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("tb_online_ball_threshold_learner: errors");
            $finish;
        end
    end

    // tvalid stays high from one beat into the next when no gap is drawn
    task automatic send_beat(logic op, logic signed [ELEM_W-1:0] v, logic ie, logic be,
                             logic p, logic [WEIGHT_W-1:0] w);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= be;
        s_tdata  <= {6'd0, w, p, ie, v};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
        learner_step(op, v, ie, be, p, w);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int val);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[LIMIT_W-1:0];
        @(posedge clk);
        if (idx == REG_CACHE_LIMIT) limit_reg = val & 8'h7f;
        else fcount_reg = val & 8'h1f;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_center(int len, bit full_range);
        for (int k = 0; k < len; k++)
            send_beat(OP_CENTER, full_range ? 16'($urandom) : 16'($urandom_range(0, 8) - 4),
                      k == len - 1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      16'($urandom));
    endtask

    // one bag: well-formed instances with occasional short or long ones
    task automatic send_bag(bit full_range);
        int ninst;
        int len;
        int n;
        logic p;
        logic [WEIGHT_W-1:0] w;
        n     = eff_features();
        ninst = $urandom_range(1, 3);
        p     = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: w = 16'($urandom_range(0, 2));
            1: w = 16'hffff;
            default: w = 16'($urandom);
        endcase
        for (int q = 0; q < ninst; q++)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n + 2) : n;
            for (int k = 0; k < len; k++)
            begin
                if (q == ninst - 1 && k == len - 1)
                    send_beat(OP_FEATURE,
                              full_range ? 16'($urandom) : 16'($urandom_range(0, 8) - 4),
                              1'($urandom_range(0, 1)), 1'b1, p, w);
                else
                    send_beat(OP_FEATURE,
                              full_range ? 16'($urandom) : 16'($urandom_range(0, 8) - 4),
                              k == len - 1, 1'b0, 1'($urandom_range(0, 1)), 16'($urandom));
            end
        end
    endtask

    task automatic test_directed();
        idle_on = 0;
        write_reg(REG_FEATURE_COUNT, 2);
        write_reg(REG_CACHE_LIMIT, 3);
        // centre at the field extremes; tlast on a centre beat is ignored
        send_beat(OP_CENTER, 16'sh7fff, 1'b0, 1'b1, 1'b1, 16'hffff);
        send_beat(OP_CENTER, 16'sh8000, 1'b1, 1'b0, 1'b0, 16'h0000);
        // zero weight bag leaves the total empty
        send_beat(OP_FEATURE, 16'sh8000, 1'b0, 1'b0, 1'b0, 16'h0);
        send_beat(OP_FEATURE, 16'sh7fff, 1'b1, 1'b1, 1'b1, 16'h0000);
        // extra elements past the feature count, then an early-ended instance
        send_beat(OP_FEATURE, 16'sh0000, 1'b0, 1'b0, 1'b0, 16'h0);
        send_beat(OP_FEATURE, 16'sh0001, 1'b0, 1'b0, 1'b0, 16'h0);
        send_beat(OP_FEATURE, 16'shffff, 1'b1, 1'b0, 1'b0, 16'h0);
        send_beat(OP_FEATURE, 16'sh7fff, 1'b1, 1'b1, 1'b0, 16'hffff);
        // equal distances and equal weights
        send_beat(OP_FEATURE, 16'sh7fff, 1'b0, 1'b0, 1'b0, 16'h0);
        send_beat(OP_FEATURE, 16'sh8000, 1'b0, 1'b1, 1'b1, 16'h0100);
        send_beat(OP_FEATURE, 16'sh7fff, 1'b0, 1'b0, 1'b0, 16'h0);
        send_beat(OP_FEATURE, 16'sh8000, 1'b1, 1'b1, 1'b0, 16'h0100);
        // cache full: lighter bag dropped, heavier evicts the lightest
        send_beat(OP_FEATURE, 16'sh0005, 1'b1, 1'b1, 1'b1, 16'h0000);
        send_beat(OP_FEATURE, 16'sh0005, 1'b1, 1'b1, 1'b1, 16'h8000);
        // lowered limit while the cache holds more
        write_reg(REG_CACHE_LIMIT, 1);
        send_beat(OP_FEATURE, 16'sh1234, 1'b1, 1'b1, 1'b1, 16'hffff);
        send_beat(OP_FEATURE, 16'sh4321, 1'b1, 1'b1, 1'b0, 16'hfffe);
        // register values outside the useful range
        write_reg(REG_CACHE_LIMIT, 0);
        write_reg(REG_FEATURE_COUNT, 0);
        send_beat(OP_FEATURE, 16'sh0001, 1'b0, 1'b1, 1'b0, 16'h0002);
        send_beat(OP_FEATURE, 16'sh0003, 1'b0, 1'b1, 1'b1, 16'h0003);
        write_reg(REG_CACHE_LIMIT, 127);
        write_reg(REG_FEATURE_COUNT, 31);
        load_center(18, 1);
        send_bag(1);
    endtask

    task automatic test_random_bags(int lim, int nf, int beats, bit with_idle);
        int stop;
        write_reg(REG_CACHE_LIMIT, lim);
        write_reg(REG_FEATURE_COUNT, nf);
        idle_on = with_idle;
        stop    = beats_sent + beats;
        load_center(eff_features(), 1'($urandom_range(0, 1)));
        while (beats_sent < stop)
        begin
            case ($urandom_range(0, 11))
                0: load_center($urandom_range(1, eff_features() + 2),
                               1'($urandom_range(0, 1)));
                1: send_beat(1'($urandom_range(0, 1)), 16'($urandom),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 16'($urandom));
                default: send_bag($urandom_range(0, 2) == 0);
            endcase
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        cycles       = 0;
        errors       = 0;
        beats_sent   = 0;
        results_seen = 0;
        drops_seen   = 0;
        accepts_seen = 0;
        stall_left   = 0;
        idle_on      = 0;
        limit_reg    = RESET_CACHE_LIMIT;
        fcount_reg   = RESET_FEATURE_COUNT;
        elem_idx     = 0;
        for (int k = 0; k < NFEAT; k++) center_val[k] = 0;
        clear_learner();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_bags(4, 3, 160, 1);
        test_random_bags(1, 1, 60, 1);
        test_random_bags(64, 16, 130, 1);
        test_random_bags(2, 2, 80, 0);
        test_random_bags(7, 5, 150, 1);

        drain();
        $display("%0d input beats, %0d result beats (%0d dropped bags, %0d accept-all)",
                 beats_sent, results_seen, drops_seen, accepts_seen);
        $display("cache limits 0..127 and feature counts 0..31 exercised");
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_online_ball_threshold_learner: clean");
        else
            $display("tb_online_ball_threshold_learner: errors");
        $finish;
    end

endmodule
